FILE: rtl/stream_byte_reassembler_assert.svh
// Assertion macros used by the reassembler back end (sbr_back).
// The first form is gated by reset; the second checks at every clock edge.
`ifndef STREAM_BYTE_REASSEMBLER_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_ASSERT_SVH
`ifndef SYNTHESIS
`define SBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SBR_ASSERT_NOW(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBR_ASSERT(name, prop, msg)
`define SBR_ASSERT_NOW(name, prop, msg)
`endif
`endif

FILE: rtl/sbr_pkg.sv
package sbr_pkg;

  localparam int unsigned IdxW           = 64;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned BufferBytesDef = 64;
  localparam int unsigned MaxResults     = 64;
  localparam int unsigned CntW           = $clog2(MaxResults + 1);
  localparam int unsigned InDepth        = 2;
  localparam int unsigned OutDepth       = 4;

  localparam logic OpData   = 1'b0;
  localparam logic OpMarker = 1'b1;

  localparam logic KindData  = 1'b0;
  localparam logic KindClose = 1'b1;

  // Input beat after the front has classified it.
  typedef struct packed {
    logic             is_marker;
    logic             has_end;
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  end_pos;
    logic [ByteW-1:0] val;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage

FILE: rtl/stream_byte_reassembler.sv
// Byte stream reassembler. Input beats (push/full) carry one byte with its
// absolute 64-bit stream index, or an empty end marker holding the end index.
// Result beats (empty/pop) carry in-order bytes and one final close beat;
// run_last_o flags the last result caused by an input beat.
// An input beat is queued by the front; the back then takes it, computes
// its window offsets and stores it, and releases its results one per
// cycle while the result queue has room (a beat that releases nothing still
// passes through the drain state). A beat causes up to 64 results; the
// drain walks the byte store one slot per cycle, when not stalled, through
// its single registered read port. A beat that only carries a close held
// back by a full drain skips the store step, and a beat that arrives after
// the close is dropped. A short queue sits on each side, so new beats are
// taken while results wait.
// If the receiver does not pop, the drain stalls when the result queue
// fills, and the input side reports full once its own queue is full. Reset
// empties both queues, clears all valid marks, sets the next expected index
// to zero and forgets any recorded end; the byte store itself is not cleared.
// After the close beat, every later input is dropped.
module stream_byte_reassembler #(
  parameter int unsigned BUFFER_BYTES = sbr_pkg::BufferBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      opcode_i,
  input  logic [sbr_pkg::IdxW-1:0]  stream_index_i,
  input  logic [sbr_pkg::ByteW-1:0] byte_value_i,
  input  logic                      final_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      out_kind_o,
  output logic [sbr_pkg::ByteW-1:0] out_byte_o,
  output logic                      run_last_o
);
  import sbr_pkg::*;

  logic     item_valid, item_pop;
  in_item_t item;
  logic     res_push, res_full;
  result_t  res_in, res_out;

  sbr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .opcode_i       (opcode_i),
    .stream_index_i (stream_index_i),
    .byte_value_i   (byte_value_i),
    .final_byte_i   (final_byte_i),
    .full_o         (full),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  sbr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  sbr_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_out)
  );

  assign out_kind_o = res_out.kind;
  assign out_byte_o = res_out.data;
  assign run_last_o = res_out.last;

endmodule

FILE: rtl/sbr_front.sv
module sbr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       opcode_i,
  input  logic [sbr_pkg::IdxW-1:0]   stream_index_i,
  input  logic [sbr_pkg::ByteW-1:0]  byte_value_i,
  input  logic                       final_byte_i,
  output logic                       full_o,
  output logic                       item_valid_o,
  output sbr_pkg::in_item_t          item_o,
  input  logic                       item_pop_i
);
  import sbr_pkg::*;

  localparam int unsigned PtrW  = (InDepth > 1) ? $clog2(InDepth) : 1;
  localparam int unsigned FillW = $clog2(InDepth + 1);

  in_item_t         fifo_q [InDepth];
  in_item_t         item_new;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  // The end position a beat carries is worked out here, before it is queued.
  always_comb begin
    item_new.is_marker = (opcode_i == OpMarker);
    item_new.has_end   = (opcode_i == OpMarker) || final_byte_i;
    item_new.idx       = stream_index_i;
    item_new.end_pos   = (opcode_i == OpMarker) ? stream_index_i
                                                 : stream_index_i + 1'b1;
    item_new.val       = byte_value_i;
  end

  assign full_o       = (fill_q == FillW'(InDepth));
  assign item_valid_o = (fill_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(InDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(InDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

FILE: rtl/sbr_out_fifo.sv
module sbr_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbr_pkg::result_t res_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output sbr_pkg::result_t res_o
);
  import sbr_pkg::*;

  localparam int unsigned PtrW  = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned FillW = $clog2(OutDepth + 1);

  result_t          fifo_q [OutDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(OutDepth));
  assign empty_o = (fill_q == '0);
  assign res_o   = fifo_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

FILE: rtl/sbr_back.sv
`include "stream_byte_reassembler_assert.svh"

module sbr_back #(
  parameter int unsigned BUFFER_BYTES = sbr_pkg::BufferBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  sbr_pkg::in_item_t item_i,
  output logic              item_pop_o,
  output logic              res_push_o,
  output sbr_pkg::result_t  res_o,
  input  logic              res_full_i
);
  import sbr_pkg::*;

  localparam int unsigned SlotW = $clog2(BUFFER_BYTES);
  localparam int unsigned OffW  = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StApply,
    StDrain
  } state_e;

  state_e                  state_q, state_d;
  in_item_t                item_q;
  logic [IdxW-1:0]         ne_q, ne_d;
  logic [SlotW-1:0]        ne_slot_q, ne_slot_d;
  logic                    ek_q, ek_d;
  logic [OffW-1:0]         rem_q, rem_d;
  logic                    closed_q, closed_d;
  logic [BUFFER_BYTES-1:0] valid_q, valid_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  logic [ByteW-1:0]        win_mem [BUFFER_BYTES];
  logic [ByteW-1:0]        rd_q;
  logic [SlotW-1:0]        rd_addr;
  logic                    mem_we;

  logic [IdxW-1:0]         d_full, de_full;
  logic                    in_win_q, end_in_q;
  logic [SlotW-1:0]        d_q;
  logic [OffW-1:0]         de_q;

  logic                    rec, ek_new, store;
  logic [OffW-1:0]         rem_new;
  logic [SlotW:0]          slot_sum;
  logic [SlotW-1:0]        wslot, slot_inc;
  logic                    data_last;

  // Offsets from the next expected index, registered so that the decision
  // in the following cycle works on narrow values only.
  assign d_full  = item_q.idx - ne_q;
  assign de_full = item_q.end_pos - ne_q;

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
    end
    in_win_q <= (d_full < IdxW'(BUFFER_BYTES));
    d_q      <= d_full[SlotW-1:0];
    end_in_q <= (de_full <= IdxW'(BUFFER_BYTES));
    de_q     <= de_full[OffW-1:0];
  end

  // While an end is known, rem_q counts the bytes still to be released before it.
  assign rec     = !ek_q && item_q.has_end && end_in_q;
  assign ek_new  = ek_q || rec;
  assign rem_new = rec ? de_q : rem_q;
  assign store   = !item_q.is_marker && in_win_q && !(ek_new && (OffW'(d_q) >= rem_new));

  assign slot_sum = {1'b0, ne_slot_q} + {1'b0, d_q};
  assign wslot    = (slot_sum >= (SlotW + 1)'(BUFFER_BYTES))
                    ? SlotW'(slot_sum - (SlotW + 1)'(BUFFER_BYTES))
                    : SlotW'(slot_sum);
  assign slot_inc = (ne_slot_q == SlotW'(BUFFER_BYTES - 1)) ? '0 : ne_slot_q + 1'b1;

  // A byte ends the run when the result budget is spent, or when nothing
  // follows it: no stored successor and no end right behind it.
  assign data_last = (cnt_q == CntW'(MaxResults - 1))
                  || (!(ek_q && (rem_q == OffW'(1))) && !valid_q[slot_inc]);

  always_comb begin
    state_d    = state_q;
    ne_d       = ne_q;
    ne_slot_d  = ne_slot_q;
    ek_d       = ek_q;
    rem_d      = rem_q;
    closed_d   = closed_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o.kind = KindData;
    res_o.data = rd_q;
    res_o.last = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = ne_slot_q;
    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = StCalc;
        end
      end
      StCalc: begin
        cnt_d = '0;
        if (closed_q) begin
          state_d = StIdle;
        end else if (ek_q && (rem_q == '0)) begin
          // A close held back by a full run goes out now; the beat is dropped.
          state_d = StDrain;
        end else begin
          state_d = StApply;
        end
      end
      StApply: begin
        ek_d  = ek_new;
        rem_d = rem_new;
        if (store) begin
          mem_we         = 1'b1;
          valid_d[wslot] = 1'b1;
        end
        state_d = StDrain;
      end
      StDrain: begin
        if (ek_q && (rem_q == '0)) begin
          res_o.kind = KindClose;
          res_o.data = '0;
          res_o.last = 1'b1;
          if (!res_full_i) begin
            res_push_o = 1'b1;
            closed_d   = 1'b1;
            state_d    = StIdle;
          end
        end else if (valid_q[ne_slot_q]) begin
          res_o.last = data_last;
          if (!res_full_i) begin
            res_push_o         = 1'b1;
            valid_d[ne_slot_q] = 1'b0;
            ne_d               = ne_q + 1'b1;
            ne_slot_d          = slot_inc;
            cnt_d              = cnt_q + 1'b1;
            rd_addr            = slot_inc;
            if (ek_q) begin
              rem_d = rem_q - 1'b1;
            end
            if (data_last) begin
              state_d = StIdle;
            end
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ne_q      <= '0;
      ne_slot_q <= '0;
      ek_q      <= 1'b0;
      rem_q     <= '0;
      closed_q  <= 1'b0;
      valid_q   <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      ne_q      <= ne_d;
      ne_slot_q <= ne_slot_d;
      ek_q      <= ek_d;
      rem_q     <= rem_d;
      closed_q  <= closed_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
    end
  end

  // Byte store. The read port always fetches the slot that is due next, and
  // a write to that same slot is forwarded.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[wslot] <= item_q.val;
    end
    if (mem_we && (wslot == rd_addr)) begin
      rd_q <= item_q.val;
    end else begin
      rd_q <= win_mem[rd_addr];
    end
  end

  `SBR_ASSERT_NOW(a_quiet_after_close, closed_q |-> !res_push_o, "result after stream close")
  `SBR_ASSERT_NOW(a_rem_in_window, ek_q |-> (rem_q <= OffW'(BUFFER_BYTES)), "end beyond window")
  `SBR_ASSERT(a_close_sets_closed, (res_push_o && (res_o.kind == KindClose)) |=> closed_q, "close lost")
  `SBR_ASSERT(a_emit_clears_slot, (res_push_o && (res_o.kind == KindData)) |=> !valid_q[$past(ne_slot_q)], "slot kept")

endmodule
